// ===== rtl/bhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_pkg
// Types and codes shared by the binary heap priority queue core: request and
// result payloads, status/command codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int KEY_W     = 32;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0]        count_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_INIT = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_READY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd2;

    typedef struct packed {
        logic cmd;
        key_t key_in;
    } request_t;

    typedef struct packed {
        status_t status;
        key_t    key_out;
        count_t  count;
        key_t    top_key;
        key_t    latest_insert;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EX_READ,
        S_EX_TAKE,
        S_UP_READ,
        S_UP_CMP,
        S_DN_READ,
        S_DN_CMP
    } state_t;

    // true when key a belongs strictly above key b
    function automatic logic ranks_above(input logic max_order, input key_t a,
                                         input key_t b);
        return max_order ? (a > b) : (a < b);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/binary_heap_priority_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Min/max binary heap of signed 32-bit keys held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request (insert or extract) is taken at a clock edge with start high
//   and busy low. Exactly one result follows, shown on result for one cycle
//   with done high; the receiver cannot stall, so nothing waits on it.
//   Configuration (heap_ready, max_order, capacity) is written through
//   cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write it only
//   while the core is idle.
// Sequence (from the accepting edge to done):
//   Rejected requests (not initialized, full, empty): done follows in the
//   next cycle, busy stays low.
//   Insert: the key climbs one level per S_UP_READ/S_UP_CMP pair; it is
//   written in S_UP_READ if it reaches the root, else in S_UP_CMP.
//   Extract: S_EX_READ then S_EX_TAKE, which ends it when the heap empties;
//   else the moved key sinks one level per S_DN_READ/S_DN_CMP pair, ending
//   in S_DN_READ on a leaf, else in S_DN_CMP. Each level takes one RAM read
//   state and one compare/write-back state.
//   A new request may be taken in the cycle done is high.
// Reset:
//   Configuration, state, done, last key and the key count clear; the RAM
//   is not cleared, only entries below the count are ever used.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_core
    import bhpq_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  request_t                   request,
    output logic                       done,
    output result_t                    result,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire  [CFG_IDX_W-1:0]       cfg_index,
    input  wire  [CNT_W-1:0]           cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW = AW + 1;
    localparam int XW = (IW > CNT_W) ? IW : CNT_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    // configuration
    logic   heap_ready_reg;
    logic   max_order_reg;
    count_t capacity_reg;

    // sequencer state
    state_t          state_reg, state_next;
    logic [AW-1:0]   pos_reg, pos_next;
    key_t            cur_reg, cur_next;
    count_t          fill_reg, fill_next;
    key_t            last_key_reg, last_key_next;
    key_t            top_reg, top_next;
    key_t            extracted_reg, extracted_next;
    result_t         result_reg, result_next;
    logic            done_reg, done_next;

    // memory ports
    key_t            heap_mem [DEPTH];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    key_t            mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr_a;
    logic [AW-1:0]   mem_raddr_b;
    key_t            rd_a_reg;
    key_t            rd_b_reg;

    logic            accept;
    logic [XW-1:0]   fill_x;
    logic [XW-1:0]   cap_x;
    logic [XW-1:0]   limit_x;
    logic [IW-1:0]   left_x;
    logic [IW-1:0]   right_x;
    logic [AW-1:0]   parent;
    logic            left_ok;
    logic            right_ok;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign fill_x   = XW'(fill_reg);
    assign cap_x    = XW'(capacity_reg);
    assign limit_x  = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
    assign left_x   = {pos_reg, 1'b1};
    assign right_x  = left_x + IW'(1);
    assign parent   = (pos_reg - AW'(1)) >> 1;
    assign left_ok  = XW'(left_x) < fill_x;
    assign right_ok = XW'(right_x) < fill_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_ready_reg <= 1'b0;
            max_order_reg  <= 1'b0;
            capacity_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEAP_READY: heap_ready_reg <= cfg_data[0];
                CFG_MAX_ORDER:  max_order_reg  <= cfg_data[0];
                CFG_CAPACITY:   capacity_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            last_key_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            last_key_reg <= last_key_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cur_reg       <= cur_next;
        top_reg       <= top_next;
        extracted_reg <= extracted_next;
        result_reg    <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_a_reg <= heap_mem[mem_raddr_a];
            rd_b_reg <= heap_mem[mem_raddr_b];
        end
    end

    always_comb
    begin
        logic          finish;
        logic          take_l;
        logic          take_r;
        key_t          best_val;
        logic [AW-1:0] best_pos;
        key_t          top_now;

        state_next     = state_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        fill_next      = fill_reg;
        last_key_next  = last_key_reg;
        extracted_next = extracted_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = cur_reg;
        mem_re         = 1'b0;
        mem_raddr_a    = '0;
        mem_raddr_b    = '0;
        finish         = 1'b0;
        take_l         = 1'b0;
        take_r         = 1'b0;
        best_val       = cur_reg;
        best_pos       = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.key_out       = '0;
                    result_next.count         = fill_reg;
                    result_next.top_key       = (fill_reg != '0) ? top_reg : '0;
                    result_next.latest_insert = last_key_reg;
                    result_next.status        = ST_OK;
                    if (!heap_ready_reg)
                    begin
                        result_next.status = ST_NOT_INIT;
                        done_next          = 1'b1;
                    end
                    else if (request.cmd == CMD_INSERT)
                    begin
                        if (fill_x >= limit_x)
                        begin
                            result_next.status = ST_FULL;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            cur_next       = request.key_in;
                            pos_next       = fill_x[AW-1:0];
                            fill_next      = fill_reg + CNT_W'(1);
                            last_key_next  = request.key_in;
                            extracted_next = '0;
                            state_next     = S_UP_READ;
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            result_next.status = ST_EMPTY;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            extracted_next = top_reg;
                            fill_next      = fill_reg - CNT_W'(1);
                            state_next     = S_EX_READ;
                        end
                    end
                end
            end

            // fetch the last entry; fill already points at it
            S_EX_READ:
            begin
                mem_re      = 1'b1;
                mem_raddr_a = fill_x[AW-1:0];
                state_next  = S_EX_TAKE;
            end

            S_EX_TAKE:
            begin
                cur_next = rd_a_reg;
                pos_next = '0;
                if (fill_reg == '0)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    state_next = S_DN_READ;
                end
            end

            S_UP_READ:
            begin
                if (pos_reg == '0)
                begin
                    mem_we = 1'b1;
                    finish = 1'b1;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr_a = parent;
                    state_next  = S_UP_CMP;
                end
            end

            // hole moves up: parent drops into pos, key stays in cur_reg
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (ranks_above(max_order_reg, cur_reg, rd_a_reg))
                begin
                    mem_wdata  = rd_a_reg;
                    pos_next   = parent;
                    state_next = S_UP_READ;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            S_DN_READ:
            begin
                if (!left_ok)
                begin
                    mem_we = 1'b1;
                    finish = 1'b1;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr_a = left_x[AW-1:0];
                    mem_raddr_b = right_x[AW-1:0];
                    state_next  = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                take_l = ranks_above(max_order_reg, rd_a_reg, cur_reg);
                if (take_l)
                begin
                    best_val = rd_a_reg;
                    best_pos = left_x[AW-1:0];
                end
                take_r = right_ok && ranks_above(max_order_reg, rd_b_reg, best_val);
                if (take_r)
                begin
                    best_val = rd_b_reg;
                    best_pos = right_x[AW-1:0];
                end
                mem_we = 1'b1;
                if (take_l || take_r)
                begin
                    mem_wdata  = best_val;
                    pos_next   = best_pos;
                    state_next = S_DN_READ;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // root mirror, so the true top is known without a RAM read
        top_now  = (mem_we && mem_waddr == '0) ? mem_wdata : top_reg;
        top_next = top_now;

        if (finish)
        begin
            state_next                = S_IDLE;
            done_next                 = 1'b1;
            result_next.status        = ST_OK;
            result_next.key_out       = extracted_reg;
            result_next.count         = fill_reg;
            result_next.top_key       = (fill_reg != '0) ? top_now : '0;
            result_next.latest_insert = last_key_reg;
        end
    end

`ifndef ASSERT_OFF
    // a result is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer busy");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_x <= DEPTH_X)
        else $error("key count exceeds depth");

    a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(fill_reg))
        else $error("key count changed without a request");

    a_not_init_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !heap_ready_reg) |=> (done_reg && !busy))
        else $error("rejected request did not complete at once");

    a_write_in_sift: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_UP_READ || state_reg == S_UP_CMP ||
                    state_reg == S_DN_READ || state_reg == S_DN_CMP))
        else $error("RAM write outside a sift step");
`endif

endmodule
`default_nettype wire
